[rtl/ssia_pkg.sv]
// Shared types, constants and the arctangent table for the segment slope/intercept/angle core.
`default_nettype none
package ssia_pkg;

  localparam int N_CORDIC = 51;
  localparam int N_TURN   = 46;
  localparam int N_DIV    = 48;
  localparam int PRESCALE = 44;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // one vectoring rotation step: x, y, z as two's complement words
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } cord_t;

  // one restoring division step: divisor, partial remainder, dividend/quotient shift
  typedef struct packed {
    logic [15:0] d;
    logic [15:0] rem;
    logic [N_DIV-1:0] sh;
  } div_t;

  // radians-to-turns division step
  typedef struct packed {
    logic [63:0] r;
    logic [N_TURN-1:0] q;
  } turn_t;

  // atan(2^-i) in Q.60 radians, alternating series for i >= 1
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] t;
    logic        add;
    int          n;
    acc = 64'd0;
    add = 1'b1;
    if (i == 0) begin
      acc = PI_Q60 >> 2;
    end else begin
      for (n = 1; n <= 59; n += 2) begin
        if (i * n <= 60) begin
          p = 64'd1 << (60 - i * n);
          unique case (n)
            1:  t = p;
            3:  t = p / 64'd3;
            5:  t = p / 64'd5;
            7:  t = p / 64'd7;
            9:  t = p / 64'd9;
            11: t = p / 64'd11;
            13: t = p / 64'd13;
            15: t = p / 64'd15;
            17: t = p / 64'd17;
            19: t = p / 64'd19;
            21: t = p / 64'd21;
            23: t = p / 64'd23;
            25: t = p / 64'd25;
            27: t = p / 64'd27;
            29: t = p / 64'd29;
            31: t = p / 64'd31;
            33: t = p / 64'd33;
            35: t = p / 64'd35;
            37: t = p / 64'd37;
            39: t = p / 64'd39;
            41: t = p / 64'd41;
            43: t = p / 64'd43;
            45: t = p / 64'd45;
            47: t = p / 64'd47;
            49: t = p / 64'd49;
            51: t = p / 64'd51;
            53: t = p / 64'd53;
            55: t = p / 64'd55;
            57: t = p / 64'd57;
            59: t = p / 64'd59;
            default: t = 64'd0;
          endcase
          acc = add ? acc + t : acc - t;
          add = ~add;
        end
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

[rtl/segment_slope_intercept_angle_core.sv]
// Top level: line through two points as slope, intercept and direction angle.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | from_x, from_y, to_x, to_y
//  output  | out_valid / out_ready| slope, intercept, angle, vertical, degenerate
//
// One word per cycle sustained; the path is one input stage, the 51 CORDIC cells,
// the 46 turn-division cells and one output stage.
// Slope and intercept dividers (48 cells each) run alongside the CORDIC chain.
// The whole chain advances together whenever the output register is empty or taken.
// Reset clears the valid bits only.
`default_nettype none
module segment_slope_intercept_angle_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] from_x,
  input  wire logic signed [15:0] from_y,
  input  wire logic signed [15:0] to_x,
  input  wire logic signed [15:0] to_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [32:0]      slope,
  output logic signed [48:0]      intercept,
  output logic [15:0]             angle,
  output logic                    vertical,
  output logic                    degenerate
);
  import ssia_pkg::*;

  localparam int LAST = N_CORDIC + N_TURN;  // index of last chain register

  typedef struct packed {
    logic dx_neg;
    logic dy_pos;
    logic dy_zero;
    logic swap;
    logic vert;
    logic degen;
    logic slope_neg;
    logic icpt_neg;
  } side_t;

  typedef struct packed {
    logic [32:0]      slope_m;
    logic [N_DIV-1:0] icpt_m;
  } res_t;

  logic  adv;
  logic  v [0:LAST];
  side_t side_q [0:LAST];
  res_t  res_q [N_DIV+1:LAST];
  cord_t cq [0:N_CORDIC];
  div_t  dsq [0:N_DIV];
  div_t  diq [0:N_DIV];
  turn_t tq [0:N_TURN];

  // input stage arithmetic
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [32:0] n;
  logic [32:0]        n_abs;
  side_t              side_in;

  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  always_comb begin
    dx    = 17'(from_x) - 17'(to_x);
    dy    = 17'(from_y) - 17'(to_y);
    ax    = dx[16] ? 16'(-dx) : dx[15:0];
    ay    = dy[16] ? 16'(-dy) : dy[15:0];
    p1    = to_y * from_x;
    p2    = from_y * to_x;
    n     = 33'(p1) - 33'(p2);
    n_abs = n[32] ? -n : n;
    side_in.dx_neg    = dx[16];
    side_in.dy_pos    = ~dy[16] & (dy != 17'sd0);
    side_in.dy_zero   = (dy == 17'sd0);
    side_in.swap      = ay > ax;
    side_in.vert      = (dx == 17'sd0);
    side_in.degen     = (dx == 17'sd0) & (dy == 17'sd0);
    side_in.slope_neg = dx[16] ^ dy[16];
    side_in.icpt_neg  = dx[16] ^ n[32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cq[0].x    <= 64'(side_in.swap ? ay : ax) << PRESCALE;
      cq[0].y    <= 64'(side_in.swap ? ax : ay) << PRESCALE;
      cq[0].z    <= 64'd0;
      dsq[0].d   <= ax;
      dsq[0].rem <= 16'd0;
      dsq[0].sh  <= {16'd0, ay, 16'd0};
      diq[0].d   <= ax;
      diq[0].rem <= 16'd0;
      diq[0].sh  <= {n_abs[31:0], 16'd0};
      side_q[0]  <= side_in;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        v[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
      for (int k = 1; k <= LAST; k++) begin
        v[k] <= v[k-1];
      end
      out_valid <= v[LAST];
    end
  end

  // flag delay line and quotient delay line
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= LAST; k++) begin
        side_q[k] <= side_q[k-1];
      end
      res_q[N_DIV+1].slope_m <= dsq[N_DIV].sh[32:0];
      res_q[N_DIV+1].icpt_m  <= diq[N_DIV].sh;
      for (int k = N_DIV + 2; k <= LAST; k++) begin
        res_q[k] <= res_q[k-1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < N_CORDIC; g++) begin : g_cordic
      ssia_cordic_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .shift (6'(g)),
        .atan  (atan_pow2(g)),
        .a     (cq[g]),
        .b     (cq[g+1])
      );
    end
    for (g = 0; g < N_DIV; g++) begin : g_div
      ssia_div_cell u_slope (
        .clk (clk),
        .en  (adv),
        .a   (dsq[g]),
        .b   (dsq[g+1])
      );
      ssia_div_cell u_icpt (
        .clk (clk),
        .en  (adv),
        .a   (diq[g]),
        .b   (diq[g+1])
      );
    end
    for (g = 0; g < N_TURN; g++) begin : g_turn
      ssia_turn_cell u_cell (
        .clk (clk),
        .en  (adv),
        .a   (tq[g]),
        .b   (tq[g+1])
      );
    end
  endgenerate

  // clamp a slightly negative angle to zero before turn division
  always_comb begin
    tq[0].r = cq[N_CORDIC].z[63] ? 64'd0 : cq[N_CORDIC].z;
    tq[0].q = '0;
  end

  // unfold octant and quadrant, round, apply signs
  logic [47:0] b_t;
  logic [47:0] th;
  logic [47:0] th_r;
  side_t       sl;
  res_t        rl;

  always_comb begin
    sl   = side_q[LAST];
    rl   = res_q[LAST];
    b_t  = sl.swap ? (48'd1 << (N_TURN - 2)) - 48'(tq[N_TURN].q) : 48'(tq[N_TURN].q);
    if (!sl.dx_neg) begin
      th = sl.dy_pos ? b_t : (48'd1 << N_TURN) - b_t;
    end else begin
      th = sl.dy_pos ? (48'd1 << (N_TURN - 1)) - b_t : (48'd1 << (N_TURN - 1)) + b_t;
    end
    th_r = th + (48'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vertical   <= sl.vert;
      degenerate <= sl.degen;
      angle      <= sl.dy_zero ? 16'd0 : th_r[45:30];
      if (sl.vert) begin
        slope     <= '0;
        intercept <= '0;
      end else begin
        slope     <= sl.slope_neg ? -$signed(rl.slope_m) : $signed(rl.slope_m);
        intercept <= sl.icpt_neg ? -$signed({1'b0, rl.icpt_m}) : $signed({1'b0, rl.icpt_m});
      end
    end
  end
endmodule
`default_nettype wire

[rtl/ssia_cordic_cell.sv]
// One vectoring CORDIC stage with its output register.
`default_nettype none
module ssia_cordic_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [5:0]     shift,
  input  wire logic [63:0]    atan,
  input  wire ssia_pkg::cord_t a,
  output ssia_pkg::cord_t      b
);
  import ssia_pkg::*;

  logic signed [63:0] sx;
  logic signed [63:0] sy;
  cord_t b_next;

  always_comb begin
    sx = $signed(a.x) >>> shift;
    sy = $signed(a.y) >>> shift;
    if (!a.y[63]) begin
      b_next.x = a.x + sy;
      b_next.y = a.y - sx;
      b_next.z = a.z + atan;
    end else begin
      b_next.x = a.x - sy;
      b_next.y = a.y + sx;
      b_next.z = a.z - atan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end
endmodule
`default_nettype wire

[rtl/ssia_div_cell.sv]
// One restoring division step (one quotient bit) with its output register.
`default_nettype none
module ssia_div_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ssia_pkg::div_t a,
  output ssia_pkg::div_t      b
);
  import ssia_pkg::*;

  logic [16:0] t;
  div_t b_next;

  always_comb begin
    t        = {a.rem, a.sh[N_DIV-1]};
    b_next.d = a.d;
    if (t >= {1'b0, a.d}) begin
      b_next.rem = 16'(t - {1'b0, a.d});
      b_next.sh  = {a.sh[N_DIV-2:0], 1'b1};
    end else begin
      b_next.rem = t[15:0];
      b_next.sh  = {a.sh[N_DIV-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end
endmodule
`default_nettype wire

[rtl/ssia_turn_cell.sv]
// One step of the radians-to-turns division by two pi, with its output register.
`default_nettype none
module ssia_turn_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire ssia_pkg::turn_t a,
  output ssia_pkg::turn_t      b
);
  import ssia_pkg::*;

  logic [63:0] r2;
  turn_t b_next;

  always_comb begin
    r2 = {a.r[62:0], 1'b0};
    if (r2 >= TWO_PI_Q60) begin
      b_next.r = r2 - TWO_PI_Q60;
      b_next.q = {a.q[N_TURN-2:0], 1'b1};
    end else begin
      b_next.r = r2;
      b_next.q = {a.q[N_TURN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end
endmodule
`default_nettype wire

[test/segment_slope_intercept_angle_core_tb.sv]
// Testbench for the segment slope/intercept/angle core: directed table plus random pairs.
`default_nettype none
module segment_slope_intercept_angle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PI_Q60_TB  = 64'h3243F6A8885A308D;
  localparam logic [63:0] TURN_Q60   = 64'h6487ED5110B4611A;
  localparam int          IDLE_LIMIT = 5000;
  localparam int          N_RANDOM   = 1880;

  typedef struct {
    logic signed [32:0] slope;
    logic signed [48:0] icpt;
    logic [15:0]        angle;
    logic               vert;
    logic               degen;
  } line_t;

  typedef struct {
    logic signed [15:0] fx, fy, tx, ty;
    logic               typed;
    line_t              want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [32:0] slope;
  logic signed [48:0] intercept;
  logic [15:0] angle;
  logic vertical, degenerate;

  line_t pending_lines[$];
  int    n_errors = 0;
  int    n_out = 0;
  int    idle_cycles = 0;
  bit    stim_done = 1'b0;

  segment_slope_intercept_angle_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .from_x(from_x), .from_y(from_y), .to_x(to_x), .to_y(to_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .slope(slope), .intercept(intercept), .angle(angle),
    .vertical(vertical), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  // atan(2^-k) in Q.60 radians
  function automatic logic [63:0] step_atan(input int k);
    logic [63:0] acc;
    logic        add;
    int          n;
    if (k == 0) return PI_Q60_TB >> 2;
    acc = '0;
    add = 1'b1;
    for (n = 1; k * n <= 60; n += 2) begin
      acc = add ? acc + ((64'd1 << (60 - k * n)) / 64'(n))
                : acc - ((64'd1 << (60 - k * n)) / 64'(n));
      add = ~add;
    end
    return acc;
  endfunction

  // first-octant angle (x >= y) as a turn fraction with 46 bits
  function automatic logic [63:0] octant_turn(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] cx, cy, z, sx, sy, r, q;
    int          k;
    cx = x << 44;
    cy = y << 44;
    z  = '0;
    for (k = 0; k < 51; k++) begin
      sx = $signed(cx) >>> k;
      sy = $signed(cy) >>> k;
      if (!cy[63]) begin
        cx = cx + sy; cy = cy - sx; z = z + step_atan(k);
      end else begin
        cx = cx - sy; cy = cy + sx; z = z - step_atan(k);
      end
    end
    if (z[63]) z = '0;
    r = z;
    q = '0;
    for (k = 0; k < 46; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= TURN_Q60) begin
        r = r - TURN_Q60;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic line_t line_of(input logic signed [15:0] fx, fy, tx, ty);
    line_t       o;
    longint      dx, dy, ax, ay;
    logic [63:0] b, th;
    dx = longint'(fx) - longint'(tx);
    dy = longint'(fy) - longint'(ty);
    o.vert  = (dx == 0);
    o.degen = (dx == 0) && (dy == 0);
    o.slope = '0;
    o.icpt  = '0;
    o.angle = '0;
    if (dx != 0) begin
      o.slope = 33'((dy * 65536) / dx);
      o.icpt  = 49'(((longint'(fy) * dx - dy * longint'(fx)) * 65536) / dx);
    end
    if (dy != 0) begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ay > ax) b = (64'd1 << 44) - octant_turn(ay, ax);
      else         b = octant_turn(ax, ay);
      if (dx >= 0) th = (dy > 0) ? b : (64'd1 << 46) - b;
      else         th = (dy > 0) ? (64'd1 << 45) - b : (64'd1 << 45) + b;
      o.angle = 16'((th + (64'd1 << 29)) >> 30);
    end
    return o;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 15)) - 16'sd8;
      1:       return 16'($urandom_range(0, 511)) - 16'sd256;
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic signed [15:0] fx, fy, tx, ty,
                           input logic typed, input line_t want);
    in_valid <= 1'b1;
    from_x <= fx; from_y <= fy; to_x <= tx; to_y <= ty;
    do @(negedge clk); while (!in_ready);
    pending_lines.push_back(typed ? want : line_of(fx, fy, tx, ty));
    @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  row_t directed[$];

  initial begin
    line_t       l;
    logic signed [15:0] fx, fy, tx, ty;
    int          burst, k;
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 49'sd0, 16'd0, 1'b1, 1'b1}},
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1,
        '{33'sd0, 49'sd0, 16'd0, 1'b1, 1'b1}},
      '{16'sd0, 16'sd5, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 49'sd0, 16'd16384, 1'b1, 1'b0}},
      '{16'sd0, -16'sd5, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 49'sd0, 16'd49152, 1'b1, 1'b0}},
      '{16'sd0, 16'sd3, 16'sd5, 16'sd3, 1'b1, '{33'sd0, 49'sd196608, 16'd0, 1'b0, 1'b0}},
      '{16'sd7, 16'sd3, 16'sd2, 16'sd3, 1'b1, '{33'sd0, 49'sd196608, 16'd0, 1'b0, 1'b0}},
      '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, '{default: '0}},
      '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, '{default: '0}},
      '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, '{default: '0}},
      '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '{default: '0}},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFE, 16'sh8000, 1'b0, '{default: '0}},
      '{16'sh7FFF, 16'sh8001, 16'sh8000, 16'sh8000, 1'b0, '{default: '0}},
      '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
      '{-16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
      '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
      '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
      '{16'sd3, 16'sd7, -16'sd2, 16'sd1, 1'b0, '{default: '0}},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '{default: '0}},
      '{16'sh1234, -16'sd4321, -16'sd77, 16'sh5A5A, 1'b0, '{default: '0}}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_word(directed[i].fx, directed[i].fy, directed[i].tx, directed[i].ty,
                directed[i].typed, directed[i].want);
    k = 0;
    while (k < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        fx = rand_coord(); fy = rand_coord();
        case ($urandom_range(0, 7))
          0:       begin tx = fx; ty = rand_coord(); end
          1:       begin tx = rand_coord(); ty = fy; end
          2:       begin tx = fx; ty = fy; end
          3:       begin tx = fx + 16'($urandom_range(0, 20)); ty = fy + (fx - tx); end
          default: begin tx = rand_coord(); ty = rand_coord(); end
        endcase
        send_word(fx, fy, tx, ty, 1'b0, l);
        k++;
        // drain the pipe once before going on
        if (k == 1200) begin
          in_valid <= 1'b0;
          while (pending_lines.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, free-running stretches, one long hold
  initial begin
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && n_out >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      case ($urandom_range(0, 2))
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(negedge clk) begin
    line_t w;
    if (!rst && out_valid && out_ready) begin
      n_out <= n_out + 1;
      if (pending_lines.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word slope %0d", $time, slope);
      end else begin
        w = pending_lines.pop_front();
        if (slope !== w.slope) begin
          n_errors++;
          $display("%0t: slope exp %0d got %0d", $time, w.slope, slope);
        end
        if (intercept !== w.icpt) begin
          n_errors++;
          $display("%0t: intercept exp %0d got %0d", $time, w.icpt, intercept);
        end
        if (angle !== w.angle) begin
          n_errors++;
          $display("%0t: angle exp %0d got %0d", $time, w.angle, angle);
        end
        if (vertical !== w.vert) begin
          n_errors++;
          $display("%0t: vertical exp %0b got %0b", $time, w.vert, vertical);
        end
        if (degenerate !== w.degen) begin
          n_errors++;
          $display("%0t: degenerate exp %0b got %0b", $time, w.degen, degenerate);
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst ||
        (stim_done && pending_lines.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (n_errors == 0 && pending_lines.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
